// ===== hw/rtl/deq_pkg.sv =====
// Shared definitions for the double-ended queue unit: request codes, field
// widths and the request descriptor passed from the front part to the back part.
// No dependencies.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int ACTION_W  = 3;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 4;
  localparam int COUNT_W   = 5;
  localparam int MAX_ADDR_W = 12;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int ITEM_WIDTH_DEFAULT = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_TDATA_W  = ((ACTION_W + DATA_W + POS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_W + COUNT_W + 1 + 7) / 8) * 8;

  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ       = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_SIZE       = 3'd5;

  typedef struct packed {
    logic                  wr;
    logic                  rd;
    logic                  err;
    logic [COUNT_W-1:0]    count;
    logic [MAX_ADDR_W-1:0] addr;
    logic [DATA_W-1:0]     data;
  } deq_op_t;

endpackage

// ===== hw/rtl/double_ended_queue_unit.sv =====
// Double-ended queue unit: one result item for each request item, in order.
// A request passes the operation queue, then the result register; one item per cycle unless out_tready is low.
// The rate is set by the single ring store port, used once per request in the back part.
// Reset clears the front pointer, the element count and the queue and result valid state.
// Ring store contents are undefined until written; no clearing pass is run.
`timescale 1ns / 1ps

module double_ended_queue_unit #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
  parameter int ITEM_WIDTH = deq_pkg::ITEM_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // action[2:0], item_value[34:3], position[38:35], zero fill[39]
  input  logic [deq_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // read_value[31:0], element_count[36:32], error_flag[37], zero fill[39:38]
  output logic [deq_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int VAL_LO = deq_pkg::ACTION_W;
  localparam int POS_LO = deq_pkg::ACTION_W + deq_pkg::DATA_W;
  localparam int OUT_USED = deq_pkg::DATA_W + deq_pkg::COUNT_W + 1;

  logic                         q_push;
  logic                         q_full;
  deq_pkg::deq_op_t             push_op;
  logic                         q_valid;
  logic                         q_ready;
  deq_pkg::deq_op_t             pop_op;
  logic [deq_pkg::DATA_W-1:0]   read_value;
  logic [deq_pkg::COUNT_W-1:0]  element_count;
  logic                         error_flag;

  deq_front #(
    .DEPTH(DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .action     (in_tdata[deq_pkg::ACTION_W-1:0]),
    .item_value (in_tdata[VAL_LO +: deq_pkg::DATA_W]),
    .position   (in_tdata[POS_LO +: deq_pkg::POS_W]),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_op       (push_op)
  );

  deq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_op   (push_op),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_op    (pop_op)
  );

  deq_back #(
    .DEPTH     (DEPTH),
    .ITEM_WIDTH(ITEM_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_op          (pop_op),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .read_value    (read_value),
    .element_count (element_count),
    .error_flag    (error_flag)
  );

  assign out_tdata = {{(deq_pkg::OUT_TDATA_W - OUT_USED){1'b0}},
                      error_flag, element_count, read_value};

`ifndef SYNTH
  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && push_op.err |-> !push_op.wr && !push_op.rd)
    else $error("failed request issues a store access");

  a_err_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && error_flag |-> read_value == '0)
    else $error("failed request returns a nonzero value");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_valid)
    else $error("input stalled with an empty operation queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> element_count <= DEPTH)
    else $error("element count exceeds the store depth");
`endif

endmodule

// ===== hw/rtl/deq_front.sv =====
// Front part of the double-ended queue unit: accepts requests, checks them
// against the front pointer and count it owns, and issues store operations.
// Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_front #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [deq_pkg::ACTION_W-1:0] action,
  input  logic [deq_pkg::DATA_W-1:0]   item_value,
  input  logic [deq_pkg::POS_W-1:0]    position,
  input  logic                         q_full,
  output logic                         q_push,
  output deq_pkg::deq_op_t             q_op
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > deq_pkg::POS_W) ? CW : deq_pkg::POS_W;

  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          full;
  logic          empty;
  logic          pos_bad;
  logic [AW-1:0] offset;
  logic [AW:0]   sum;
  logic [AW-1:0] slot;
  logic [AW-1:0] ptr_dec;
  logic [AW-1:0] ptr_inc;
  logic          err;
  logic          wr;
  logic          rd;
  logic [AW-1:0] addr;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign pos_bad = (PW'(position) >= PW'(cnt_r));
  assign ptr_dec = (ptr_r == '0) ? AW'(DEPTH - 1) : ptr_r - AW'(1);
  assign ptr_inc = (ptr_r == AW'(DEPTH - 1)) ? '0 : ptr_r + AW'(1);

  always_comb begin
    unique case (action)
      deq_pkg::ACT_PUSH_BACK: offset = AW'(cnt_r);
      deq_pkg::ACT_POP_BACK:  offset = AW'(cnt_r - CW'(1));
      default:                offset = AW'(position);
    endcase
  end

  assign sum  = {1'b0, ptr_r} + {1'b0, offset};
  assign slot = (sum >= (AW + 1)'(DEPTH)) ? AW'(sum - (AW + 1)'(DEPTH)) : AW'(sum);

  always_comb begin
    ptr_nxt = ptr_r;
    cnt_nxt = cnt_r;
    err     = 1'b0;
    wr      = 1'b0;
    rd      = 1'b0;
    addr    = slot;
    unique case (action)
      deq_pkg::ACT_PUSH_FRONT: begin
        err  = full;
        wr   = !full;
        addr = ptr_dec;
        if (!full) begin
          ptr_nxt = ptr_dec;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      deq_pkg::ACT_PUSH_BACK: begin
        err = full;
        wr  = !full;
        if (!full) begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      deq_pkg::ACT_POP_FRONT: begin
        err  = empty;
        rd   = !empty;
        addr = ptr_r;
        if (!empty) begin
          ptr_nxt = ptr_inc;
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      deq_pkg::ACT_POP_BACK: begin
        err = empty;
        rd  = !empty;
        if (!empty) begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      deq_pkg::ACT_READ: begin
        err = pos_bad;
        rd  = !pos_bad;
      end
      default: begin
      end
    endcase
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_op       = '0;
    q_op.wr    = wr;
    q_op.rd    = rd;
    q_op.err   = err;
    q_op.count = deq_pkg::COUNT_W'(cnt_nxt);
    q_op.addr  = deq_pkg::MAX_ADDR_W'(addr);
    q_op.data  = item_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      cnt_r <= '0;
    end else if (q_push) begin
      ptr_r <= ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/deq_queue.sv =====
// Short operation queue between the front and back parts of the
// double-ended queue unit. Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  deq_pkg::deq_op_t push_op,
  output logic             full,
  output logic             pop_valid,
  input  logic             pop_ready,
  output deq_pkg::deq_op_t pop_op
);

  deq_pkg::deq_op_t                entries_r [deq_pkg::QUEUE_DEPTH];
  logic [deq_pkg::QPTR_W-1:0]      wptr_r, wptr_nxt;
  logic [deq_pkg::QPTR_W-1:0]      rptr_r, rptr_nxt;
  logic [deq_pkg::QCNT_W-1:0]      fill_r, fill_nxt;
  logic                            pop;

  assign full      = (fill_r == deq_pkg::QCNT_W'(deq_pkg::QUEUE_DEPTH));
  assign pop_valid = (fill_r != '0);
  assign pop_op    = entries_r[rptr_r];
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    fill_nxt = fill_r;
    if (push) begin
      wptr_nxt = (wptr_r == deq_pkg::QPTR_W'(deq_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wptr_r + deq_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == deq_pkg::QPTR_W'(deq_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rptr_r + deq_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + deq_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - deq_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wptr_r] <= push_op;
    end
  end

endmodule

// ===== hw/rtl/deq_back.sv =====
// Back part of the double-ended queue unit: holds the ring store, carries out
// queued writes and reads in order, and keeps the result register.
// Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_back #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
  parameter int ITEM_WIDTH = deq_pkg::ITEM_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  deq_pkg::deq_op_t             q_op,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [deq_pkg::DATA_W-1:0]   read_value,
  output logic [deq_pkg::COUNT_W-1:0]  element_count,
  output logic                         error_flag
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = (ITEM_WIDTH < deq_pkg::DATA_W) ? ITEM_WIDTH : deq_pkg::DATA_W;

  logic [SW-1:0]               mem [DEPTH];
  logic [SW-1:0]               rdata_r;
  logic                        use_r;
  logic [deq_pkg::COUNT_W-1:0] count_r;
  logic                        err_r;
  logic                        valid_r, valid_nxt;
  logic                        take;
  logic [AW-1:0]               addr;

  assign addr    = q_op.addr[AW-1:0];
  assign take    = q_valid && (!valid_r || out_ready);
  assign q_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && q_op.wr) begin
      mem[addr] <= q_op.data[SW-1:0];
    end
    if (take) begin
      rdata_r <= mem[addr];
      use_r   <= q_op.rd;
      count_r <= q_op.count;
      err_r   <= q_op.err;
    end
  end

  assign out_valid     = valid_r;
  assign read_value    = use_r ? deq_pkg::DATA_W'(rdata_r) : '0;
  assign element_count = count_r;
  assign error_flag    = err_r;

endmodule
